>>> src/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
package lrupr_pkg;

   localparam int PAGE_W    = 16;
   localparam int FIDX_W    = 4;
   localparam int FCNT_W    = 32;
   localparam int CSR_W     = 5;
   localparam int CNT_N_W   = 7;
   localparam logic [CSR_W-1:0] FRAMES_RST = 5'd16;

   // Search record walking down the chain (index and stamp fields travel alongside).
   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic              hit;
      logic              empty;
      logic              min_set;
      logic [PAGE_W-1:0] min_page;
   } rec_type;

   // Update sent to all cells once the decision is made.
   typedef struct packed {
      logic              en;
      logic              load;
      logic [PAGE_W-1:0] page;
   } wb_type;

endpackage

>>> src/lrupr_cell.sv
// One frame cell: holds page, valid bit and stamp, and folds itself into the passing record.
module lrupr_cell
   import lrupr_pkg::*;
#(
   parameter int INDEX      = 0,
   parameter int IDX_W      = 4,
   parameter int STAMP_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  active,
   input  logic                  rec_valid_i,
   input  rec_type               rec_i,
   input  logic [IDX_W-1:0]      sel_idx_i,
   input  logic [IDX_W-1:0]      min_idx_i,
   input  logic [STAMP_BITS-1:0] min_stamp_i,
   output logic                  rec_valid_o,
   output rec_type               rec_o,
   output logic [IDX_W-1:0]      sel_idx_o,
   output logic [IDX_W-1:0]      min_idx_o,
   output logic [STAMP_BITS-1:0] min_stamp_o,
   input  wb_type                wb,
   input  logic [IDX_W-1:0]      wb_idx,
   input  logic [STAMP_BITS-1:0] wb_stamp
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [PAGE_W-1:0]     page_ff;
   logic                  valid_ff;
   logic [STAMP_BITS-1:0] stamp_ff;

   logic                  rec_valid_ff;
   rec_type               rec_ff, rec_in;
   logic [IDX_W-1:0]      sel_idx_ff, sel_idx_in;
   logic [IDX_W-1:0]      min_idx_ff, min_idx_in;
   logic [STAMP_BITS-1:0] min_stamp_ff, min_stamp_in;

   logic match;
   logic wb_hit;

   assign match  = valid_ff && (page_ff == rec_i.page);
   assign wb_hit = wb.en && (wb_idx == MY_IDX);

   always_comb begin
      rec_in       = rec_i;
      sel_idx_in   = sel_idx_i;
      min_idx_in   = min_idx_i;
      min_stamp_in = min_stamp_i;
      if (active) begin
         // first hit wins; otherwise remember the first empty frame
         if (!rec_i.hit) begin
            if (match) begin
               rec_in.hit = 1'b1;
               sel_idx_in = MY_IDX;
            end else if (!rec_i.empty && !valid_ff) begin
               rec_in.empty = 1'b1;
               sel_idx_in   = MY_IDX;
            end
         end
         // strict compare keeps the lowest index on ties
         if (!rec_i.min_set || (stamp_ff < min_stamp_i)) begin
            rec_in.min_set  = 1'b1;
            rec_in.min_page = page_ff;
            min_idx_in      = MY_IDX;
            min_stamp_in    = stamp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         stamp_ff     <= '0;
         rec_valid_ff <= 1'b0;
      end else begin
         rec_valid_ff <= rec_valid_i;
         if (wb_hit) begin
            stamp_ff <= wb_stamp;
            if (wb.load) begin
               valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff       <= rec_in;
      sel_idx_ff   <= sel_idx_in;
      min_idx_ff   <= min_idx_in;
      min_stamp_ff <= min_stamp_in;
      if (wb_hit && wb.load) begin
         page_ff <= wb.page;
      end
   end

   assign rec_valid_o = rec_valid_ff;
   assign rec_o       = rec_ff;
   assign sel_idx_o   = sel_idx_ff;
   assign min_idx_o   = min_idx_ff;
   assign min_stamp_o = min_stamp_ff;

endmodule

>>> src/lru_page_replacement.sv
// LRU page replacement with last-use stamps. Each reference walks a chain of FRAMES cells, one
// cell per clock, each cell checking its frame for a hit, the first empty frame and the oldest
// stamp; the decision is then written back to the chosen cell and the result registered. A new
// reference is accepted only after the previous one has walked the whole cell chain and been
// written back; the result register lets the next reference enter while the previous result
// still waits. The frames_in_use register (reset 16) is taken as 1 when zero and as FRAMES
// when larger; frames beyond it keep their contents but are skipped.
module lru_page_replacement
   import lrupr_pkg::*;
#(
   parameter int FRAMES     = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [PAGE_W-1:0] req_page_number,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_fault,
   output logic [FIDX_W-1:0] rsp_frame_index,
   output logic              rsp_evicted_valid,
   output logic [PAGE_W-1:0] rsp_evicted_page,
   output logic [FCNT_W-1:0] rsp_fault_count,
   input  logic              csr_wr_en,
   input  logic [CSR_W-1:0]  csr_wr_data
);

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CSR_W-1:0]      frames_ff;
   logic [STAMP_BITS-1:0] ref_ff;
   logic [FCNT_W-1:0]     fault_ff;
   logic [CNT_N_W-1:0]    active_n;
   logic [CNT_N_W-1:0]    frames_ext;

   logic                  req_take;
   logic                  rsp_free;

   // chain taps
   logic                  c_valid   [FRAMES+1];
   rec_type               c_rec     [FRAMES+1];
   logic [IDX_W-1:0]      c_sel     [FRAMES+1];
   logic [IDX_W-1:0]      c_min     [FRAMES+1];
   logic [STAMP_BITS-1:0] c_stamp   [FRAMES+1];

   // decision held for write-back
   logic                  d_fault_ff, d_fault_in;
   logic                  d_evict_ff, d_evict_in;
   logic [IDX_W-1:0]      d_slot_ff, d_slot_in;
   logic [PAGE_W-1:0]     d_page_ff, d_page_in;
   logic [PAGE_W-1:0]     d_evpage_ff, d_evpage_in;

   wb_type                wb;
   logic [IDX_W+FIDX_W-1:0] slot_ext;

   logic                  rsp_valid_ff;
   logic                  rsp_fault_ff;
   logic [FIDX_W-1:0]     rsp_frame_ff;
   logic                  rsp_evict_ff;
   logic [PAGE_W-1:0]     rsp_evpage_ff;
   logic [FCNT_W-1:0]     rsp_count_ff;
   logic [FCNT_W-1:0]     fault_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign frames_ext = {{(CNT_N_W-CSR_W){1'b0}}, frames_ff};
   always_comb begin
      if (frames_ext == '0) begin
         active_n = CNT_N_W'(1);
      end else if (frames_ext > CNT_N_W'(FRAMES)) begin
         active_n = CNT_N_W'(FRAMES);
      end else begin
         active_n = frames_ext;
      end
   end

   // head of the chain: a fresh record from the accepted request
   assign c_valid[0]          = req_take;
   assign c_rec[0].page       = req_page_number;
   assign c_rec[0].hit        = 1'b0;
   assign c_rec[0].empty      = 1'b0;
   assign c_rec[0].min_set    = 1'b0;
   assign c_rec[0].min_page   = '0;
   assign c_sel[0]            = '0;
   assign c_min[0]            = '0;
   assign c_stamp[0]          = '0;

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      lrupr_cell #(
         .INDEX      (i),
         .IDX_W      (IDX_W),
         .STAMP_BITS (STAMP_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .active      (CNT_N_W'(i) < active_n),
         .rec_valid_i (c_valid[i]),
         .rec_i       (c_rec[i]),
         .sel_idx_i   (c_sel[i]),
         .min_idx_i   (c_min[i]),
         .min_stamp_i (c_stamp[i]),
         .rec_valid_o (c_valid[i+1]),
         .rec_o       (c_rec[i+1]),
         .sel_idx_o   (c_sel[i+1]),
         .min_idx_o   (c_min[i+1]),
         .min_stamp_o (c_stamp[i+1]),
         .wb          (wb),
         .wb_idx      (d_slot_ff),
         .wb_stamp    (ref_ff)
      );
   end

   // decode the record leaving the last cell
   always_comb begin
      d_page_in   = c_rec[FRAMES].page;
      d_evpage_in = '0;
      d_evict_in  = 1'b0;
      d_fault_in  = 1'b1;
      d_slot_in   = c_sel[FRAMES];
      if (c_rec[FRAMES].hit) begin
         d_fault_in = 1'b0;
      end else if (!c_rec[FRAMES].empty) begin
         d_slot_in   = c_min[FRAMES];
         d_evict_in  = 1'b1;
         d_evpage_in = c_rec[FRAMES].min_page;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (c_valid[FRAMES]) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign wb.en   = (state_ff == ST_FINISH) && rsp_free;
   assign wb.load = d_fault_ff;
   assign wb.page = d_page_ff;

   assign fault_next = (d_fault_ff && (fault_ff != '1)) ? fault_ff + FCNT_W'(1) : fault_ff;
   assign slot_ext   = {{FIDX_W{1'b0}}, d_slot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frames_ff    <= FRAMES_RST;
         ref_ff       <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            frames_ff <= csr_wr_data;
         end
         // saturate the reference number
         if (req_take && (ref_ff != '1)) begin
            ref_ff <= ref_ff + STAMP_BITS'(1);
         end
         if (wb.en) begin
            fault_ff     <= fault_next;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_SEARCH) && c_valid[FRAMES]) begin
         d_fault_ff  <= d_fault_in;
         d_evict_ff  <= d_evict_in;
         d_slot_ff   <= d_slot_in;
         d_page_ff   <= d_page_in;
         d_evpage_ff <= d_evpage_in;
      end
      if (wb.en) begin
         rsp_fault_ff  <= d_fault_ff;
         rsp_frame_ff  <= slot_ext[FIDX_W-1:0];
         rsp_evict_ff  <= d_evict_ff;
         rsp_evpage_ff <= d_evpage_ff;
         rsp_count_ff  <= fault_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fault         = rsp_fault_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_evict_ff;
   assign rsp_evicted_page  = rsp_evpage_ff;
   assign rsp_fault_count   = rsp_count_ff;

endmodule
